@@ hw/rtl/sgm_pkg.sv @@
// Shared types, constants and the arctangent table of the Sobel block.
`timescale 1ns / 1ps
package sgm_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_ANGLE_FRAC_BITS = 12;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int COORD_W = 10;
  localparam int MAG_W = 8;
  localparam int ANG_W = 15;
  localparam int GRAD_W = 11;
  localparam int SQ_W = 21;
  localparam int RT_W = 17;
  localparam int CORD_W = 36;
  localparam int CORDIC_STEPS = 24;
  localparam int IT_W = 5;
  localparam int GRAD_SHIFT = 20;
  localparam logic signed [CORD_W-1:0] PI_Q30 = 36'sd3373259426;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_LOAD,
    S_INIT,
    S_CALC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic win;
    logic load;
    logic init;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic pend_any;
    logic more;
    logic iter_last;
  } stat_t;

  function automatic logic signed [CORD_W-1:0] atan_q30(input logic [IT_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h3243F6A8;
      5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;
      5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;
      5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;
      5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;
      5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return signed'({4'b0, v});
  endfunction

endpackage

@@ hw/rtl/sgm_pix_if.sv @@
// Pixel input channel: valid, ready and one gray pixel per beat.
`timescale 1ns / 1ps
interface sgm_pix_if;
  logic valid;
  logic ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

@@ hw/rtl/sgm_res_if.sv @@
// Result channel: valid, ready and one gradient result per beat.
`timescale 1ns / 1ps
interface sgm_res_if;
  logic valid;
  logic ready;
  logic [sgm_pkg::COORD_W-1:0] out_col;
  logic [sgm_pkg::COORD_W-1:0] out_row;
  logic [sgm_pkg::MAG_W-1:0] magnitude;
  logic signed [sgm_pkg::ANG_W-1:0] angle;
  logic last;
  modport source (output valid, output out_col, output out_row, output magnitude,
                  output angle, output last, input ready);
  modport sink (input valid, input out_col, input out_row, input magnitude,
                input angle, input last, output ready);
endinterface

@@ hw/rtl/sgm_ctrl.sv @@
// Sequencer for the Sobel block: one pixel at a time, one result after another.
`timescale 1ns / 1ps
module sgm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sgm_pkg::stat_t   stat,
  output sgm_pkg::cmd_t    cmd
);

  sgm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sgm_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgm_pkg::S_IDLE: if (in_valid) state_nxt = sgm_pkg::S_WIN;
      sgm_pkg::S_WIN:  state_nxt = stat.pend_any ? sgm_pkg::S_LOAD : sgm_pkg::S_IDLE;
      sgm_pkg::S_LOAD: state_nxt = sgm_pkg::S_INIT;
      sgm_pkg::S_INIT: state_nxt = sgm_pkg::S_CALC;
      sgm_pkg::S_CALC: if (stat.iter_last) state_nxt = sgm_pkg::S_OUT;
      sgm_pkg::S_OUT: begin
        if (out_ready) state_nxt = stat.more ? sgm_pkg::S_LOAD : sgm_pkg::S_IDLE;
      end
      default: state_nxt = sgm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == sgm_pkg::S_IDLE);
    out_valid = (state_r == sgm_pkg::S_OUT);
    cmd.accept = in_ready && in_valid;
    cmd.win = (state_r == sgm_pkg::S_WIN);
    cmd.load = (state_r == sgm_pkg::S_LOAD);
    cmd.init = (state_r == sgm_pkg::S_INIT);
    cmd.step = (state_r == sgm_pkg::S_CALC);
  end

endmodule

@@ hw/rtl/sgm_datapath.sv @@
// Line stores, window, counters, iterative root and CORDIC of the Sobel block.
`timescale 1ns / 1ps
module sgm_datapath #(
  parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT,
  parameter int ANGLE_FRAC_BITS = sgm_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgm_pkg::cmd_t                      cmd,
  output sgm_pkg::stat_t                     stat,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [sgm_pkg::PIX_W-1:0]          pixel,
  output logic [sgm_pkg::COORD_W-1:0]        res_col,
  output logic [sgm_pkg::COORD_W-1:0]        res_row,
  output logic [sgm_pkg::MAG_W-1:0]          res_mag,
  output logic signed [sgm_pkg::ANG_W-1:0]   res_ang,
  output logic                               res_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WB = CW + 1;
  localparam int HB = RW + 1;
  localparam int CB = sgm_pkg::CORD_W;
  localparam int GW = sgm_pkg::GRAD_W;
  localparam int PW = 2 * GW;

  // configuration
  logic [sgm_pkg::CFG_W-1:0] fw_r, fh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd640;
      fh_r <= 11'd480;
    end else if (cfg_we) begin
      if (cfg_index == sgm_pkg::REG_FRAME_WIDTH) fw_r <= cfg_wdata;
      if (cfg_index == sgm_pkg::REG_FRAME_HEIGHT) fh_r <= cfg_wdata;
    end
  end

  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  always_comb begin
    if (fw_r < 11'd3) w_eff = WB'(3);
    else if (32'(fw_r) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(fw_r);
    if (fh_r < 11'd3) h_eff = HB'(3);
    else if (32'(fh_r) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(fh_r);
  end

  // counters and position of the accepted pixel
  logic [CW-1:0] col_r, c_r, c_now;
  logic [RW-1:0] row_r, r_r, r_now;
  logic [WB-1:0] c_inc;
  logic [HB-1:0] r_inc;
  logic int_now, bdr_now;

  always_comb begin
    c_now = (WB'(col_r) >= w_eff) ? '0 : col_r;
    r_now = (HB'(row_r) >= h_eff) ? '0 : row_r;
    c_inc = WB'(c_now) + WB'(1);
    r_inc = HB'(r_now) + HB'(1);
    int_now = (r_now >= RW'(2)) && (c_now >= CW'(2));
    bdr_now = (r_now == '0) || (c_now == '0) || (HB'(r_now) == h_eff - HB'(1)) ||
              (WB'(c_now) == w_eff - WB'(1));
  end

  logic int_pend_r, bdr_pend_r, sel_int_r;
  logic [sgm_pkg::PIX_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      int_pend_r <= 1'b0;
      bdr_pend_r <= 1'b0;
      sel_int_r <= 1'b0;
    end else if (cmd.accept) begin
      int_pend_r <= int_now;
      bdr_pend_r <= bdr_now;
      if (c_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (r_inc >= h_eff) ? '0 : RW'(r_inc);
      end else begin
        col_r <= CW'(c_inc);
      end
    end else if (cmd.load) begin
      sel_int_r <= int_pend_r;
      if (int_pend_r) int_pend_r <= 1'b0;
      else bdr_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r <= pixel;
      c_r <= c_now;
      r_r <= r_now;
    end
  end

  // line stores
  logic [sgm_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [sgm_pkg::PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [sgm_pkg::PIX_W-1:0] up_rd_r, lo_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      up_rd_r <= upper_mem[c_now];
      lo_rd_r <= lower_mem[c_now];
    end
    if (cmd.win) begin
      upper_mem[c_r] <= lo_rd_r;
      lower_mem[c_r] <= p_r;
    end
  end

  // window: [row][col], col 2 newest
  logic [sgm_pkg::PIX_W-1:0] win_r [3][3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win_r[k][j] <= '0;
    end else if (cmd.win) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up_rd_r;
      win_r[1][2] <= lo_rd_r;
      win_r[2][2] <= p_r;
    end
  end

  logic signed [GW-1:0] gx_win, gy_win;
  always_comb begin
    gx_win = (GW'(win_r[0][2]) + (GW'(win_r[1][2]) << 1) + GW'(win_r[2][2])) -
             (GW'(win_r[0][0]) + (GW'(win_r[1][0]) << 1) + GW'(win_r[2][0]));
    gy_win = (GW'(win_r[2][0]) + (GW'(win_r[2][1]) << 1) + GW'(win_r[2][2])) -
             (GW'(win_r[0][0]) + (GW'(win_r[0][1]) << 1) + GW'(win_r[0][2]));
  end

  // load the selected result
  logic signed [GW-1:0] gx_r, gy_r;
  logic [sgm_pkg::COORD_W-1:0] oc_r, or_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (int_pend_r) begin
        gx_r <= gx_win;
        gy_r <= gy_win;
        oc_r <= sgm_pkg::COORD_W'(c_r - CW'(1));
        or_r <= sgm_pkg::COORD_W'(r_r - RW'(1));
      end else begin
        gx_r <= GW'(p_r);
        gy_r <= GW'(p_r);
        oc_r <= sgm_pkg::COORD_W'(c_r);
        or_r <= sgm_pkg::COORD_W'(r_r);
      end
    end
  end

  // iterative root and CORDIC
  logic signed [PW-1:0] gx_sq, gy_sq;
  logic [sgm_pkg::SQ_W-1:0] sq;
  logic [sgm_pkg::RT_W-1:0] rv_r, rres_r, rbit_r, rsum;
  logic sat_r, zero_r;
  logic signed [CB-1:0] x_r, y_r, z_r, xs, ys, gxw, gyw;
  logic [sgm_pkg::IT_W-1:0] it_r;

  always_comb begin
    gx_sq = gx_r * gx_r;
    gy_sq = gy_r * gy_r;
    sq = sgm_pkg::SQ_W'(gx_sq) + sgm_pkg::SQ_W'(gy_sq);
    gxw = CB'(gx_r) <<< sgm_pkg::GRAD_SHIFT;
    gyw = CB'(gy_r) <<< sgm_pkg::GRAD_SHIFT;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    rsum = rres_r + rbit_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      sat_r <= (sq >= sgm_pkg::SQ_W'(65536));
      rv_r <= sgm_pkg::RT_W'(sq[15:0]);
      rres_r <= '0;
      rbit_r <= sgm_pkg::RT_W'(1) << 14;
      zero_r <= (gx_r == '0) && (gy_r == '0);
      it_r <= '0;
      if (gx_r < 0) begin
        x_r <= -gxw;
        y_r <= -gyw;
        z_r <= (gy_r >= 0) ? sgm_pkg::PI_Q30 : -sgm_pkg::PI_Q30;
      end else begin
        x_r <= gxw;
        y_r <= gyw;
        z_r <= '0;
      end
    end else if (cmd.step) begin
      it_r <= it_r + 1'b1;
      if (rbit_r != '0) begin
        if (rv_r >= rsum) begin
          rv_r <= rv_r - rsum;
          rres_r <= (rres_r >> 1) + rbit_r;
        end else begin
          rres_r <= rres_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
      end
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + sgm_pkg::atan_q30(it_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - sgm_pkg::atan_q30(it_r);
      end
    end
  end

  // round Q30 to the output fraction, ties away from zero
  logic signed [CB-1:0] zm, zq, zang;
  always_comb begin
    zm = (z_r < 0) ? -z_r : z_r;
    zq = (zm + (CB'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    zang = (z_r < 0) ? -zq : zq;
  end

  assign res_col = oc_r;
  assign res_row = or_r;
  assign res_mag = sat_r ? 8'd255 : sgm_pkg::MAG_W'(rres_r);
  assign res_ang = zero_r ? '0 : zang[sgm_pkg::ANG_W-1:0];
  assign res_last = !(sel_int_r && bdr_pend_r);

  assign stat.pend_any = int_pend_r || bdr_pend_r;
  assign stat.more = bdr_pend_r;
  assign stat.iter_last = (it_r == sgm_pkg::IT_W'(sgm_pkg::CORDIC_STEPS - 1));

endmodule

@@ hw/rtl/sobel_gradient_magnitude_direction.sv @@
// Top level of the 3x3 Sobel edge detector with gradient magnitude and angle.
// Sequence: a pixel is taken, the window and line stores update, then each
// result goes through load, setup and 24 CORDIC iterations before its beat.
// No new pixel is taken until every result of the last one (at most two per
// pixel) has been handed out; the shared 24-step CORDIC sets the pace.
// Reset (rst_n low, synchronous): counters, window and sequencer clear, registers
// return to 640 x 480; line store contents stay undefined until written.
`timescale 1ns / 1ps
module sobel_gradient_magnitude_direction #(
  parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT,
  parameter int ANGLE_FRAC_BITS = sgm_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sgm_pix_if.sink                   in_chan,
  sgm_res_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0] cfg_wdata
);

  sgm_pkg::cmd_t  cmd;
  sgm_pkg::stat_t stat;

  // Sequencer: accepts a beat only when idle, walks the results out one by one.
  sgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: line stores, window, root and angle units; results held in
  // registers while the output beat waits.
  sgm_datapath #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel     (in_chan.pixel),
    .res_col   (out_chan.out_col),
    .res_row   (out_chan.out_row),
    .res_mag   (out_chan.magnitude),
    .res_ang   (out_chan.angle),
    .res_last  (out_chan.last)
  );

  // One pixel at a time: never accept while a result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input taken while a result is pending");

  // A taken pixel closes the input for the next cycle.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input stayed open after a beat");

  // The final result of a pixel returns the block to idle.
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last) |=> in_chan.ready)
    else $error("block did not return to idle after last result");

  // A result that is not last is followed by another result, never by input.
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=> !in_chan.ready)
    else $error("second result dropped");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the streaming Sobel gradient magnitude and angle block.
`timescale 1ns / 1ps
module testbench;

  localparam int  SETTLE_CYCLES = 60;       // a pixel without a result may still be in flight
  localparam int  LIMIT_CYCLES  = 4_000_000;
  localparam int  IDLE_PCT      = 38;
  localparam int  HOLD_CYCLES   = 400;
  localparam longint PI_FIX     = 64'sd3373259426;

  typedef struct {
    logic [sgm_pkg::COORD_W-1:0]       col;
    logic [sgm_pkg::COORD_W-1:0]       row;
    logic [sgm_pkg::MAG_W-1:0]         mag;
    logic signed [sgm_pkg::ANG_W-1:0]  ang;
    logic                              last;
  } gradient_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [sgm_pkg::CFG_W-1:0] cfg_wdata;

  sgm_pix_if pix ();
  sgm_res_if res ();

  sobel_gradient_magnitude_direction u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (pix),
    .out_chan  (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block: line stores, window, raster counters, frame size.
  logic [sgm_pkg::PIX_W-1:0] line_up [sgm_pkg::DEF_MAX_WIDTH];
  logic [sgm_pkg::PIX_W-1:0] line_lo [sgm_pkg::DEF_MAX_WIDTH];
  logic [sgm_pkg::PIX_W-1:0] win [3][3];
  int unsigned pos_col, pos_row;
  int unsigned frame_w, frame_h;

  gradient_t pending_grads[$];
  int  errors;
  int  cycles;
  bit  calm;      // when set neither side idles
  bit  hold_out;  // receiver holds off entirely

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-length guard: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, none while calm, none at all while holding off.
  always @(negedge clk) begin
    res.ready <= rst_n && !hold_out && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // Compare each result beat against the oldest expected gradient.
  always @(posedge clk) begin
    gradient_t exp_g;
    if (rst_n && res.valid && res.ready) begin
      if (pending_grads.size() == 0) begin
        report($sformatf("unexpected beat col=%0d row=%0d", res.out_col, res.out_row));
      end else begin
        exp_g = pending_grads.pop_front();
        if (res.out_col !== exp_g.col)
          report($sformatf("col got %0d want %0d", res.out_col, exp_g.col));
        if (res.out_row !== exp_g.row)
          report($sformatf("row got %0d want %0d", res.out_row, exp_g.row));
        if (res.magnitude !== exp_g.mag)
          report($sformatf("magnitude at (%0d,%0d) got %0d want %0d",
                           exp_g.row, exp_g.col, res.magnitude, exp_g.mag));
        if (res.angle !== exp_g.ang)
          report($sformatf("angle at (%0d,%0d) got %0d want %0d",
                           exp_g.row, exp_g.col, res.angle, exp_g.ang));
        if (res.last !== exp_g.last)
          report($sformatf("last at (%0d,%0d) got %0b want %0b",
                           exp_g.row, exp_g.col, res.last, exp_g.last));
      end
    end
  end

  function automatic int floor_root(input int s);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic longint atan_step(input int i);
    longint t [sgm_pkg::CORDIC_STEPS] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // Vectoring CORDIC in Q30, rounded half away from zero to the angle fraction.
  function automatic logic signed [sgm_pkg::ANG_W-1:0] gradient_angle(input int gx,
                                                                      input int gy);
    longint x, y, z, xs, ys, m, q;
    if (gx == 0 && gy == 0) return '0;
    x = longint'(gx) * 1048576;
    y = longint'(gy) * 1048576;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (gy >= 0) ? PI_FIX : -PI_FIX;
    end
    for (int i = 0; i < sgm_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    m = (z < 0) ? -z : z;
    q = (m + (64'sd1 << (29 - sgm_pkg::DEF_ANGLE_FRAC_BITS))) >>>
        (30 - sgm_pkg::DEF_ANGLE_FRAC_BITS);
    return (z < 0) ? sgm_pkg::ANG_W'(-q) : sgm_pkg::ANG_W'(q);
  endfunction

  function automatic gradient_t make_gradient(input int unsigned c, input int unsigned r,
                                              input int gx, input int gy);
    gradient_t g;
    int s;
    s = gx * gx + gy * gy;
    g.col  = sgm_pkg::COORD_W'(c);
    g.row  = sgm_pkg::COORD_W'(r);
    g.mag  = (s >= 65536) ? 8'd255 : sgm_pkg::MAG_W'(floor_root(s));
    g.ang  = gradient_angle(gx, gy);
    g.last = 1'b0;
    return g;
  endfunction

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the shadow block by one accepted pixel and queue what it yields.
  task automatic predict_pixel(input logic [sgm_pkg::PIX_W-1:0] p);
    int unsigned w, h, c, r;
    int a [3][3];
    int gx, gy, n;
    w = clamp_size(frame_w, sgm_pkg::DEF_MAX_WIDTH);
    h = clamp_size(frame_h, sgm_pkg::DEF_MAX_HEIGHT);
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_up[c];
    win[1][2] = line_lo[c];
    win[2][2] = p;
    line_up[c] = line_lo[c];
    line_lo[c] = p;
    n = 0;
    if (r >= 2 && c >= 2) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a[i][j] = win[i][j];
      gx = (a[0][2] + 2 * a[1][2] + a[2][2]) - (a[0][0] + 2 * a[1][0] + a[2][0]);
      gy = (a[2][0] + 2 * a[2][1] + a[2][2]) - (a[0][0] + 2 * a[0][1] + a[0][2]);
      pending_grads.push_back(make_gradient(c - 1, r - 1, gx, gy));
      n++;
    end
    // Border pixels pass straight through with both gradients equal to the pixel.
    if (r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
      pending_grads.push_back(make_gradient(c, r, p, p));
      n++;
    end
    if (n > 0) pending_grads[$].last = 1'b1;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // Offer one pixel, with random gaps, and hold it until the block takes the beat.
  task automatic send_pixel(input logic [sgm_pkg::PIX_W-1:0] p);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    do @(posedge clk); while (!pix.ready);
    predict_pixel(p);
    @(negedge clk);
  endtask

  task automatic stop_pixels();
    pix.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [sgm_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sgm_pkg::REG_FRAME_WIDTH) frame_w = v;
    else frame_h = v;
    @(negedge clk);
  endtask

  // Wait out every expected beat plus the pipeline tail of result-free pixels.
  task automatic drain();
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame(input logic [sgm_pkg::CFG_W-1:0] w,
                           input logic [sgm_pkg::CFG_W-1:0] h);
    drain();
    write_reg(sgm_pkg::REG_FRAME_WIDTH, w);
    write_reg(sgm_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // Pixel styles: 0 random, 1 only black or white, 2 ramps, 3 extremes and noise.
  function automatic logic [sgm_pkg::PIX_W-1:0] pick_pixel(input int style,
                                                           input int unsigned c,
                                                           input int unsigned r);
    case (style)
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      2: return sgm_pkg::PIX_W'(c * 37 + r * 11);
      3: return ($urandom_range(3) == 0) ? sgm_pkg::PIX_W'($urandom) :
                ($urandom_range(1) ? 8'hFF : 8'h00);
      default: return sgm_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // Send exactly one full frame so the raster counters end back at the origin.
  task automatic send_frame(input int style);
    int unsigned w, h;
    w = clamp_size(frame_w, sgm_pkg::DEF_MAX_WIDTH);
    h = clamp_size(frame_h, sgm_pkg::DEF_MAX_HEIGHT);
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++)
        send_pixel(pick_pixel(style, c, r));
    stop_pixels();
  endtask

  // Flat black frame gives zero gradients and a zero angle; then a hard
  // black/white checker drives saturation, and a 4 x 3 ramp frame follows.
  task automatic test_directed();
    set_frame(11'd3, 11'd3);
    repeat (9) send_pixel(8'h00);
    stop_pixels();
    set_frame(11'd4, 11'd4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_pixel(((r + c) % 2 == 0) ? 8'hFF : 8'h00);
    stop_pixels();
    set_frame(11'd4, 11'd3);
    send_frame(2);
  endtask

  // Sizes outside the legal range act as the nearest bound; a row count left
  // past a shrunk height restarts at the top on the next pixel.
  task automatic test_size_extremes();
    calm = 1'b1;
    set_frame(11'h7FF, 11'd0);     // 1024 wide, 3 high: first row only
    for (int unsigned c = 0; c < 1024; c++)
      send_pixel(pick_pixel(3, c, 0));
    stop_pixels();
    set_frame(11'd2, 11'd1030);    // 3 wide, 1024 high: rows 1 to 4
    for (int unsigned r = 1; r < 5; r++)
      for (int unsigned c = 0; c < 3; c++)
        send_pixel(pick_pixel(0, c, r));
    stop_pixels();
    set_frame(11'd3, 11'd3);       // row count wraps, then one full frame
    send_frame(1);
    calm = 1'b0;
  endtask

  // Small random frames with random content; one frame runs under a long hold-off.
  task automatic test_random_frames();
    int sent;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < 450) begin
      set_frame(11'($urandom_range(3, 9)), 11'($urandom_range(3, 8)));
      if (!held && sent > 300) begin
        held = 1'b1;
        fork
          begin
            hold_out = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_out = 1'b0;
          end
        join_none
      end
      send_frame($urandom_range(3));
      sent += clamp_size(frame_w, sgm_pkg::DEF_MAX_WIDTH) *
              clamp_size(frame_h, sgm_pkg::DEF_MAX_HEIGHT);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = sgm_pkg::REG_FRAME_WIDTH;
    cfg_wdata = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    res.ready = 1'b0;
    errors    = 0;
    cycles    = 0;
    calm      = 1'b0;
    hold_out  = 1'b0;
    for (int i = 0; i < sgm_pkg::DEF_MAX_WIDTH; i++) begin
      line_up[i] = '0;
      line_lo[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    pos_col = 0;
    pos_row = 0;
    frame_w = 640;
    frame_h = 480;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_frames();
    test_size_extremes();

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_pix_if.sv
hw/rtl/sgm_res_if.sv
hw/rtl/sgm_ctrl.sv
hw/rtl/sgm_datapath.sv
hw/rtl/sobel_gradient_magnitude_direction.sv
verif/testbench.sv
